>>> hdl/m2ds_pkg.sv
`timescale 1ns / 1ps

package m2ds_pkg;

  // Line store geometry, all derived from the widest fine row.
  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int IDX_W      = $clog2(LINE_DEPTH);

  // Field widths fixed by the pixel format.
  localparam int CHAN_W   = 8;
  localparam int NCHAN    = 4;
  localparam int SUM_W    = CHAN_W + 1;
  localparam int ACC_W    = CHAN_W + 2;
  localparam int NUM_W    = CHAN_W + 3;
  localparam int CNT_W    = 2;
  localparam int ACNT_W   = 3;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FINE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_HEIGHT = 1'd1;

  localparam logic [WIDTH_W-1:0]  FINE_WIDTH_RESET  = 13'd640;
  localparam logic [HEIGHT_W-1:0] FINE_HEIGHT_RESET = 16'd480;

  // Division by three: floor(v * 683 / 2048) is exact for v below 2048.
  localparam logic [NUM_W-1:0] RECIP3       = 11'd683;
  localparam int               RECIP3_SHIFT = 11;

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
    logic              in_hole;
    logic              in_known;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              out_hole;
    logic              out_known;
    logic              frame_end;
  } coarse_t;

  // One line store entry: top-row partial sums of a block.
  typedef struct packed {
    logic [NCHAN-1:0][SUM_W-1:0] known_sum;
    logic [NCHAN-1:0][SUM_W-1:0] all_sum;
    logic [CNT_W-1:0]            known_cnt;
    logic [CNT_W-1:0]            child_cnt;
    logic                        hole;
    logic                        known;
  } line_entry_t;

  localparam int LINE_W = $bits(line_entry_t);

  // Channels of a pixel, red at index zero.
  function automatic logic [NCHAN-1:0][CHAN_W-1:0] pixel_chan(input pixel_t p);
    pixel_chan = {p.in_alpha, p.in_blue, p.in_green, p.in_red};
  endfunction

endpackage

>>> hdl/m2ds_ram.sv
`timescale 1ns / 1ps

module m2ds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port that holds while not enabled.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/masked_two_by_two_downsample_unit.sv
`timescale 1ns / 1ps

// Masked 2x2 box downsampler. Fine RGBA pixels enter in raster order on the
// in_valid / in_stall channel, one word per pixel, each with a hole and a
// known flag. One coarse word leaves on out_valid / out_stall for every 2x2
// block, or partial block at an odd right or bottom edge, carrying the
// rounded mean colour of the known children (of all children when none is
// known), the OR of the hole flags and the AND of the known flags.
// Throughput is one pixel per cycle while the receiver takes each coarse
// word; the pipeline moves as one, so no pixel is taken while a finished
// coarse word is held off.
// After the block's last pixel is accepted, the coarse word passes the block
// stage (line store read and sums), the divide stage and the registered
// output. The line store is a single-port-write, registered-read RAM of
// half a row; a read that meets the write of the same entry in one cycle is
// forwarded. When out_stall is high with a word waiting, the whole pipeline
// holds and in_stall rises. Reset restores a 640 by 480 frame and restarts
// at the top left; a configuration write also restarts the frame. The line
// store needs no clearing, since each entry is written before it is read.

module masked_two_by_two_downsample_unit
  import m2ds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pixel_t               in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output coarse_t              out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration and frame position.
  logic [WIDTH_W-1:0]  fine_width;
  logic [HEIGHT_W-1:0] fine_height;
  logic [COL_W-1:0]    column_position;
  logic [HEIGHT_W-1:0] row_position;
  pixel_t              left_child_pixel;

  logic [WIDTH_W-1:0]  eff_width;
  logic [HEIGHT_W-1:0] eff_height;
  logic                last_col;
  logic                last_row;
  logic                odd_col;
  logic                odd_row;
  logic [IDX_W-1:0]    idx;
  logic                advance;
  logic                accept;

  // Block stage, fed at accept; line data arrives with it.
  logic             b_valid;
  logic             b_odd_col;
  logic             b_odd_row;
  logic             b_last_row;
  logic             b_frame_end;
  logic [IDX_W-1:0] b_idx;
  pixel_t           b_px;
  pixel_t           b_left;
  logic             fwd_hit;
  line_entry_t      fwd_data;

  // Divide stage.
  logic                         c_valid;
  logic [NCHAN-1:0][NUM_W-1:0]  c_num;
  logic [ACNT_W-1:0]            c_cnt;
  logic                         c_hole;
  logic                         c_known;
  logic                         c_frame_end;

  logic [LINE_W-1:0]           rd_raw;
  line_entry_t                 line_in;
  line_entry_t                 line_out;
  logic                        line_wr;
  logic [NCHAN-1:0][ACC_W-1:0] ks_acc;
  logic [NCHAN-1:0][ACC_W-1:0] as_acc;
  logic [ACNT_W-1:0]           n_acc;
  logic [ACNT_W-1:0]           m_acc;
  logic                        hole_acc;
  logic                        known_acc;
  logic [ACNT_W-1:0]           cnt_sel;
  logic [NCHAN-1:0][NUM_W-1:0] num_sel;
  logic [NCHAN-1:0][CHAN_W-1:0] left_ch;
  logic [NCHAN-1:0][CHAN_W-1:0] px_ch;
  logic [NCHAN-1:0][CHAN_W-1:0] quot;
  logic [NCHAN-1:0][2*NUM_W-1:0] prod3;

  // Effective frame size and position decode.
  always_comb begin
    eff_width = fine_width;
    if (fine_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (32'(fine_width) > MAX_WIDTH) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end
    eff_height = (fine_height == '0) ? HEIGHT_W'(1) : fine_height;
    last_col   = (32'(column_position) + 32'd1) >= 32'(eff_width);
    last_row   = (32'(row_position) + 32'd1) >= 32'(eff_height);
    odd_col    = column_position[0];
    odd_row    = row_position[0];
    idx        = IDX_W'(column_position >> 1);
  end

  // The whole pipeline moves unless a finished word is held off.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Configuration registers and raster position.
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_width       <= FINE_WIDTH_RESET;
      fine_height      <= FINE_HEIGHT_RESET;
      column_position  <= '0;
      row_position     <= '0;
      left_child_pixel <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FINE_WIDTH: begin
          fine_width <= cfg_data[WIDTH_W-1:0];
        end
        REG_FINE_HEIGHT: begin
          fine_height <= cfg_data[HEIGHT_W-1:0];
        end
        default: begin
        end
      endcase
      column_position  <= '0;
      row_position     <= '0;
      left_child_pixel <= '0;
    end else if (accept) begin
      if (!odd_col) begin
        left_child_pixel <= in_data;
      end
      if (last_col) begin
        column_position <= '0;
        row_position    <= last_row ? '0 : row_position + HEIGHT_W'(1);
      end else begin
        column_position <= column_position + COL_W'(1);
      end
    end
  end

  // Line store of top-row block sums.
  m2ds_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (b_idx),
    .wr_data (line_out),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_raw)
  );

  assign line_in = fwd_hit ? fwd_data : line_entry_t'(rd_raw);
  assign line_wr = b_valid && !b_odd_row && advance;

  // Block stage control; a same-cycle write of the entry being read is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (advance) begin
      b_valid <= accept && (odd_col || last_col) && !cfg_write;
      if (accept) begin
        fwd_hit <= line_wr && (b_idx == idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_odd_col   <= odd_col;
      b_odd_row   <= odd_row;
      b_last_row  <= last_row;
      b_frame_end <= last_col && last_row;
      b_idx       <= idx;
      b_px        <= in_data;
      b_left      <= left_child_pixel;
      fwd_data    <= line_out;
    end
  end

  // Accumulate the block: stored top row, then the left child and this pixel.
  always_comb begin
    left_ch   = pixel_chan(b_left);
    px_ch     = pixel_chan(b_px);
    ks_acc    = '0;
    as_acc    = '0;
    n_acc     = '0;
    m_acc     = '0;
    hole_acc  = 1'b0;
    known_acc = 1'b1;
    if (b_odd_row) begin
      for (int c = 0; c < NCHAN; c++) begin
        ks_acc[c] = ACC_W'(line_in.known_sum[c]);
        as_acc[c] = ACC_W'(line_in.all_sum[c]);
      end
      n_acc     = ACNT_W'(line_in.known_cnt);
      m_acc     = ACNT_W'(line_in.child_cnt);
      hole_acc  = line_in.hole;
      known_acc = line_in.known;
    end
    if (b_odd_col) begin
      for (int c = 0; c < NCHAN; c++) begin
        as_acc[c] = as_acc[c] + ACC_W'(left_ch[c]);
        if (b_left.in_known) begin
          ks_acc[c] = ks_acc[c] + ACC_W'(left_ch[c]);
        end
      end
      m_acc     = m_acc + ACNT_W'(1);
      n_acc     = n_acc + ACNT_W'(b_left.in_known);
      hole_acc  = hole_acc | b_left.in_hole;
      known_acc = known_acc & b_left.in_known;
    end
    for (int c = 0; c < NCHAN; c++) begin
      as_acc[c] = as_acc[c] + ACC_W'(px_ch[c]);
      if (b_px.in_known) begin
        ks_acc[c] = ks_acc[c] + ACC_W'(px_ch[c]);
      end
    end
    m_acc     = m_acc + ACNT_W'(1);
    n_acc     = n_acc + ACNT_W'(b_px.in_known);
    hole_acc  = hole_acc | b_px.in_hole;
    known_acc = known_acc & b_px.in_known;

    // Entry written back in a top row.
    for (int c = 0; c < NCHAN; c++) begin
      line_out.known_sum[c] = ks_acc[c][SUM_W-1:0];
      line_out.all_sum[c]   = as_acc[c][SUM_W-1:0];
    end
    line_out.known_cnt = n_acc[CNT_W-1:0];
    line_out.child_cnt = m_acc[CNT_W-1:0];
    line_out.hole      = hole_acc;
    line_out.known     = known_acc;

    // Known children win; otherwise all children. Rounding adds half the count.
    cnt_sel = (n_acc != '0) ? n_acc : m_acc;
    for (int c = 0; c < NCHAN; c++) begin
      num_sel[c] = (n_acc != '0) ? NUM_W'(ks_acc[c]) : NUM_W'(as_acc[c]);
      num_sel[c] = num_sel[c] + NUM_W'(cnt_sel >> 1);
    end
  end

  // Divide stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (advance) begin
      c_valid <= b_valid && (b_odd_row || b_last_row);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_num       <= num_sel;
      c_cnt       <= cnt_sel;
      c_hole      <= hole_acc;
      c_known     <= known_acc;
      c_frame_end <= b_frame_end;
    end
  end

  // Divide by a child count of one to four.
  always_comb begin
    for (int c = 0; c < NCHAN; c++) begin
      prod3[c] = (2*NUM_W)'(c_num[c]) * (2*NUM_W)'(RECIP3);
      case (c_cnt)
        3'd1: begin
          quot[c] = c_num[c][CHAN_W-1:0];
        end
        3'd2: begin
          quot[c] = c_num[c][CHAN_W:1];
        end
        3'd3: begin
          quot[c] = prod3[c][RECIP3_SHIFT +: CHAN_W];
        end
        3'd4: begin
          quot[c] = c_num[c][CHAN_W+1:2];
        end
        default: begin
          quot[c] = '0;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_red   <= quot[0];
      out_data.out_green <= quot[1];
      out_data.out_blue  <= quot[2];
      out_data.out_alpha <= quot[3];
      out_data.out_hole  <= c_hole;
      out_data.out_known <= c_known;
      out_data.frame_end <= c_frame_end;
    end
  end

endmodule

>>> tb/sv/masked_two_by_two_downsample_unit_tb.sv
`timescale 1ns / 1ps

module masked_two_by_two_downsample_unit_tb;
  import m2ds_pkg::*;

  localparam int RANDOM_ITEMS  = 300;
  localparam int WIDE_ITEMS    = 64;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int EXPECT_DEPTH  = 64;

  // Receiver behaviour during one stretch of cycles.
  localparam int RX_FREE   = 0;
  localparam int RX_PATCHY = 1;
  localparam int RX_BUSY   = 2;

  // Top-row partial sums of one block, as the predictor keeps them.
  typedef struct packed {
    logic [NCHAN-1:0][SUM_W-1:0] known_sum;
    logic [NCHAN-1:0][SUM_W-1:0] all_sum;
    logic [CNT_W-1:0]            known_cnt;
    logic [CNT_W-1:0]            child_cnt;
    logic                        hole;
    logic                        known;
  } top_sums_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  pixel_t               in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  coarse_t              out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FINE_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Predictor state.
  top_sums_t           top_sums [LINE_DEPTH];
  pixel_t              left_px = '0;
  int                  col_pos = 0;
  int                  row_pos = 0;
  logic [WIDTH_W-1:0]  fine_w  = FINE_WIDTH_RESET;
  logic [HEIGHT_W-1:0] fine_h  = FINE_HEIGHT_RESET;

  // Expected coarse words, kept in a ring with running head and tail counts.
  coarse_t expected_coarse [EXPECT_DEPTH];
  int      expected_head = 0;
  int      expected_tail = 0;
  int      mismatches   = 0;
  int      burst_left   = 0;
  int      stretch_left = 0;
  int      stall_mode   = RX_FREE;
  bit      hold_request = 1'b0;

  masked_two_by_two_downsample_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the coarse word, if any, that one fine pixel completes.
  function automatic bit downsample_step(input pixel_t px, output coarse_t word);
    int w, h, idx, n, m, k, c, first;
    int ksum [NCHAN];
    int asum [NCHAN];
    int mean [NCHAN];
    logic [CHAN_W-1:0] chan [NCHAN];
    pixel_t kids [2];
    logic hole_or, known_and;
    bit last_col, last_row, odd_col, odd_row, emit;
    w = (fine_w == 0) ? 1 : ((int'(fine_w) > MAX_WIDTH) ? MAX_WIDTH : int'(fine_w));
    h = (fine_h == 0) ? 1 : int'(fine_h);
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    odd_col = (col_pos % 2) != 0;
    odd_row = (row_pos % 2) != 0;
    idx = col_pos / 2;
    if (idx >= LINE_DEPTH) idx = LINE_DEPTH - 1;
    emit = 1'b0;
    word = '0;
    if (!odd_col) left_px = px;
    if (odd_col || last_col) begin
      n = 0;
      m = 0;
      hole_or = 1'b0;
      known_and = 1'b1;
      for (c = 0; c < NCHAN; c++) begin
        ksum[c] = 0;
        asum[c] = 0;
      end
      // The bottom row picks up what the top row left in the line store.
      if (odd_row) begin
        for (c = 0; c < NCHAN; c++) begin
          ksum[c] = top_sums[idx].known_sum[c];
          asum[c] = top_sums[idx].all_sum[c];
        end
        n = top_sums[idx].known_cnt;
        m = top_sums[idx].child_cnt;
        hole_or = top_sums[idx].hole;
        known_and = top_sums[idx].known;
      end
      kids[0] = left_px;
      kids[1] = px;
      first = odd_col ? 0 : 1;
      for (k = first; k < 2; k++) begin
        chan[0] = kids[k].in_red;
        chan[1] = kids[k].in_green;
        chan[2] = kids[k].in_blue;
        chan[3] = kids[k].in_alpha;
        for (c = 0; c < NCHAN; c++) begin
          asum[c] += chan[c];
          if (kids[k].in_known) ksum[c] += chan[c];
        end
        m++;
        if (kids[k].in_known) n++;
        hole_or = hole_or | kids[k].in_hole;
        known_and = known_and & kids[k].in_known;
      end
      if (!odd_row) begin
        for (c = 0; c < NCHAN; c++) begin
          top_sums[idx].known_sum[c] = SUM_W'(ksum[c]);
          top_sums[idx].all_sum[c] = SUM_W'(asum[c]);
        end
        top_sums[idx].known_cnt = CNT_W'(n);
        top_sums[idx].child_cnt = CNT_W'(m);
        top_sums[idx].hole = hole_or;
        top_sums[idx].known = known_and;
      end
      // Mean of the known children, falling back to all children.
      if (odd_row || last_row) begin
        for (c = 0; c < NCHAN; c++) begin
          if (n != 0) mean[c] = (ksum[c] + n / 2) / n;
          else if (m != 0) mean[c] = (asum[c] + m / 2) / m;
          else mean[c] = 0;
        end
        word.out_red   = CHAN_W'(mean[0]);
        word.out_green = CHAN_W'(mean[1]);
        word.out_blue  = CHAN_W'(mean[2]);
        word.out_alpha = CHAN_W'(mean[3]);
        word.out_hole  = hole_or;
        word.out_known = known_and;
        word.frame_end = last_col && last_row;
        emit = 1'b1;
      end
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) % 65536);
    end else begin
      col_pos++;
    end
    return emit;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Checks each coarse word taken and predicts from each fine word taken.
  always @(posedge clk) begin : monitor
    coarse_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_tail == expected_head) begin
          $error("coarse word with nothing expected");
          mismatches++;
        end else begin
          want = expected_coarse[expected_head % EXPECT_DEPTH];
          expected_head++;
          check_field("out_red", want.out_red, out_data.out_red);
          check_field("out_green", want.out_green, out_data.out_green);
          check_field("out_blue", want.out_blue, out_data.out_blue);
          check_field("out_alpha", want.out_alpha, out_data.out_alpha);
          check_field("out_hole", want.out_hole, out_data.out_hole);
          check_field("out_known", want.out_known, out_data.out_known);
          check_field("frame_end", want.frame_end, out_data.frame_end);
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_FINE_WIDTH) fine_w = cfg_data[WIDTH_W-1:0];
        else if (cfg_index == REG_FINE_HEIGHT) fine_h = cfg_data[HEIGHT_W-1:0];
        col_pos = 0;
        row_pos = 0;
        left_px = '0;
      end else if (in_valid && !in_stall) begin
        if (downsample_step(in_data, want)) begin
          expected_coarse[expected_tail % EXPECT_DEPTH] = want;
          expected_tail++;
        end
      end
    end
  end

  // Receiver: changing stall patterns, and one long hold when asked.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (stretch_left == 0) begin
          stall_mode = $urandom_range(RX_FREE, RX_BUSY);
          stretch_left = $urandom_range(4, 60);
        end
        stretch_left--;
        case (stall_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_PATCHY: out_stall <= ($urandom_range(0, 2) == 0);
          default:   out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Ends the run when nothing has moved for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Offers one fine word until taken, then perhaps pauses between bursts.
  task automatic send_pixel(input pixel_t p);
    int gap;
    @(negedge clk);
    in_data <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Lets every expected coarse word out and the pipeline drain.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tail != expected_head) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(REG_FINE_WIDTH, w);
    write_reg(REG_FINE_HEIGHT, h);
  endtask

  function automatic pixel_t mk_pixel(int r, int g, int b, int a, bit hole, bit known);
    pixel_t p;
    p.in_red   = CHAN_W'(r);
    p.in_green = CHAN_W'(g);
    p.in_blue  = CHAN_W'(b);
    p.in_alpha = CHAN_W'(a);
    p.in_hole  = hole;
    p.in_known = known;
    return p;
  endfunction

  // Channel values lean towards the extremes now and then.
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel(int known_pct, int hole_pct);
    return mk_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                    $urandom_range(1, 100) <= hole_pct, $urandom_range(1, 100) <= known_pct);
  endfunction

  task automatic send_frame(int count, int known_pct, int hole_pct);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel(known_pct, hole_pct));
  endtask

  // The reset size of 640 columns: one full row and the start of the next.
  task automatic test_reset_size();
    send_frame(FINE_WIDTH_RESET + 10, 70, 30);
  endtask

  // Hand-picked blocks: full, right edge, bottom edge, corner, no known child.
  task automatic test_directed_blocks();
    set_size(16'd4, 16'd2);
    send_pixel(mk_pixel(255, 255, 255, 255, 1'b0, 1'b1));
    send_pixel(mk_pixel(255, 255, 255, 255, 1'b0, 1'b1));
    send_pixel(mk_pixel(0, 0, 0, 0, 1'b1, 1'b0));
    send_pixel(mk_pixel(10, 20, 30, 40, 1'b0, 1'b1));
    send_pixel(mk_pixel(255, 255, 255, 255, 1'b0, 1'b1));
    send_pixel(mk_pixel(255, 255, 255, 255, 1'b1, 1'b1));
    send_pixel(mk_pixel(7, 8, 9, 1, 1'b0, 1'b1));
    send_pixel(mk_pixel(200, 100, 50, 3, 1'b0, 1'b1));
    set_size(16'd3, 16'd3);
    send_pixel(mk_pixel(0, 0, 0, 0, 1'b0, 1'b0));
    send_pixel(mk_pixel(1, 2, 3, 4, 1'b0, 1'b0));
    send_pixel(mk_pixel(255, 255, 255, 255, 1'b0, 1'b0));
    send_pixel(mk_pixel(3, 3, 3, 3, 1'b0, 1'b0));
    send_pixel(mk_pixel(0, 0, 0, 0, 1'b1, 1'b0));
    send_pixel(mk_pixel(128, 128, 128, 128, 1'b0, 1'b1));
    send_pixel(mk_pixel(255, 0, 255, 0, 1'b0, 1'b1));
    send_pixel(mk_pixel(0, 255, 0, 255, 1'b1, 1'b0));
    send_pixel(mk_pixel(99, 99, 99, 99, 1'b1, 1'b1));
    // A zero size counts as one, so every pixel ends a frame.
    set_size(16'd0, 16'd0);
    send_pixel(mk_pixel(255, 0, 128, 1, 1'b1, 1'b0));
    send_pixel(mk_pixel(0, 255, 127, 254, 1'b0, 1'b1));
  endtask

  // Random small sizes, whole frames and frames cut short by a restart.
  task automatic test_random_frames();
    int sent, w, h, count, known_pct, hole_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 12);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      set_size({3'($urandom_range(0, 7)), 13'(w)}, 16'(h));
      case ($urandom_range(0, 3))
        0:       known_pct = 0;
        1:       known_pct = 50;
        2:       known_pct = 90;
        default: known_pct = 100;
      endcase
      hole_pct = $urandom_range(0, 50);
      count = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      send_frame(count, known_pct, hole_pct);
      sent += count;
    end
  endtask

  // A long receiver hold while pixels keep coming, so the input stalls.
  task automatic test_output_hold();
    set_size(16'd2, 16'd64);
    hold_request = 1'b1;
    send_frame(256, 80, 20);
  endtask

  // Tallest frame: only its first rows are sent; the width register ignores high bits.
  task automatic test_tall_frame();
    set_size(16'h2005, 16'hFFFF);
    send_frame(37, 60, 40);
  endtask

  // Widest rows: exactly the maximum, then a width that saturates; the start of one row each.
  task automatic test_wide_rows();
    set_size(16'd4096, 16'd1);
    send_frame(WIDE_ITEMS, 75, 25);
    set_size(16'hFFFF, 16'd1);
    send_frame(WIDE_ITEMS, 75, 25);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_size();
    test_directed_blocks();
    test_random_frames();
    test_output_hold();
    test_tall_frame();
    test_wide_rows();
    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
